[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the velocity dispersion modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WVD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define WVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

[design/wvd_pkg.sv]
// ----------------------------------------------------------------------------
// wvd_pkg
// Types and fixed constants shared by the velocity dispersion modules.
// ----------------------------------------------------------------------------
package wvd_pkg;

   localparam int INDEX_W     = 20;
   localparam int SLOT_MAX_W  = 6;
   localparam int COUNT_MAX_W = 6;
   localparam int STEP_W      = 6;
   localparam int DIV_STEPS   = 48;
   localparam int ROOT_STEPS  = 24;
   localparam logic [23:0] DISP_SAT = 24'hFFFFFF;

   typedef struct packed {
      logic [23:0]        mass;
      logic signed [23:0] radial_velocity;
      logic signed [23:0] tangential_velocity;
      logic [31:0]        radius;
      logic               last_object;
   } req_type;

   typedef struct packed {
      logic [19:0] object_index;
      logic [31:0] out_radius;
      logic [23:0] dispersion;
      logic [23:0] mean_mass;
      logic        window_error;
      logic        last_result;
   } rsp_type;

   // One unit of work handed from the front end to the back end.
   typedef struct packed {
      logic [55:0]             energy_sum;
      logic [29:0]             mass_sum;
      logic [INDEX_W-1:0]      first_index;
      logic [SLOT_MAX_W-1:0]   first_slot;
      logic [COUNT_MAX_W-1:0]  result_count;
      logic [31:0]             radius;
      logic                    use_mem;
      logic                    window_error;
      logic                    last_result;
   } job_type;

   typedef struct packed {
      logic                  idle;
      logic [SLOT_MAX_W-1:0] rd_slot;
   } back_status_type;

   typedef enum logic [2:0] {
      F_IDLE, F_SQUARE, F_PRODUCT, F_SUM, F_PUSH, F_DRAIN
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_DIV, B_ROOT, B_READ, B_LOAD
   } back_state_type;

endpackage

[design/wvd_queue.sv]
// ----------------------------------------------------------------------------
// wvd_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wvd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wvd_pkg::job_type  push_job,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output wvd_pkg::job_type  pop_job
);

   wvd_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       fill_ff;

   assign full    = (fill_ff == 2'd2);
   assign empty   = (fill_ff == 2'd0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `WVD_ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !full)
   `WVD_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, !empty)

endmodule

[design/wvd_front.sv]
// ----------------------------------------------------------------------------
// wvd_front
// Takes one object, forms its energy term, keeps the window stores and
// running sums, and hands a job to the back end.
// ----------------------------------------------------------------------------
module wvd_front #(
   parameter int HalfWindow = 20,
   parameter int MaxObjects = 1048576
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  wvd_pkg::req_type         req_data,
   output logic                     push,
   output wvd_pkg::job_type         push_job,
   input  logic                     queue_full,
   input  logic                     queue_empty,
   input  wvd_pkg::back_status_type back_status,
   output logic [31:0]              back_radius
);

   localparam int WindowLen  = 2 * HalfWindow;
   localparam int SlotWidth  = $clog2(WindowLen);
   localparam int CountWidth = $clog2(MaxObjects);

   wvd_pkg::front_state_type state_ff, state_in;

   logic [23:0]           mass_mem   [WindowLen];
   logic [47:0]           energy_mem [WindowLen];
   logic [31:0]           radius_mem [WindowLen];

   logic [SlotWidth-1:0]  slot_ff;
   logic [CountWidth-1:0] count_ff;
   logic                  full_ff;
   logic [55:0]           energy_sum_ff;
   logic [29:0]           mass_sum_ff;

   logic [23:0]           mass_ff;
   logic [23:0]           mag_a_ff;
   logic [23:0]           mag_b_ff;
   logic [31:0]           radius_ff;
   logic                  last_ff;
   logic [23:0]           old_mass_ff;
   logic [47:0]           old_energy_ff;
   logic [SlotWidth-1:0]  emit_slot_ff;
   logic [31:0]           radius_emit_ff;
   logic [47:0]           v2_ff;
   logic [47:0]           prod_hi_ff;
   logic [47:0]           prod_lo_ff;
   logic [31:0]           back_radius_ff;
   wvd_pkg::job_type      job_ff, job_in;
   logic                  has_job;

   logic                  accept;
   logic [SlotWidth:0]    emit_wide;
   logic [SlotWidth-1:0]  emit_slot;
   logic [SlotWidth-1:0]  slot_next;
   logic                  slot_wrap;
   logic [47:0]           sq_a;
   logic [47:0]           sq_b;
   logic [47:0]           energy;
   logic [55:0]           energy_sum_new;
   logic [29:0]           mass_sum_new;
   logic                  first_job;

   assign back_radius = back_radius_ff;
   assign push_job    = job_ff;

   // Slot of the object whose result becomes known with this one.
   assign emit_wide = {1'b0, slot_ff} + (SlotWidth + 1)'(HalfWindow + 1);
   assign emit_slot = (emit_wide >= (SlotWidth + 1)'(WindowLen))
                    ? SlotWidth'(emit_wide - (SlotWidth + 1)'(WindowLen))
                    : SlotWidth'(emit_wide);
   assign slot_wrap = (slot_ff == SlotWidth'(WindowLen - 1));
   assign slot_next = slot_wrap ? '0 : slot_ff + 1'b1;

   assign sq_a   = mag_a_ff * mag_a_ff;
   assign sq_b   = mag_b_ff * mag_b_ff;
   assign energy = prod_hi_ff + (prod_lo_ff >> 24);

   assign energy_sum_new = energy_sum_ff - (full_ff ? {8'd0, old_energy_ff} : 56'd0)
                         + {8'd0, energy};
   assign mass_sum_new   = mass_sum_ff - (full_ff ? {6'd0, old_mass_ff} : 30'd0)
                         + {6'd0, mass_ff};
   assign first_job      = !full_ff && slot_wrap;

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      accept    = 1'b0;
      push      = 1'b0;
      unique case (state_ff)
         wvd_pkg::F_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               accept   = 1'b1;
               state_in = wvd_pkg::F_SQUARE;
            end
         end
         wvd_pkg::F_SQUARE: begin
            state_in = wvd_pkg::F_PRODUCT;
         end
         wvd_pkg::F_PRODUCT: begin
            state_in = wvd_pkg::F_SUM;
         end
         wvd_pkg::F_SUM: begin
            state_in = has_job ? wvd_pkg::F_PUSH : wvd_pkg::F_IDLE;
         end
         wvd_pkg::F_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = job_ff.use_mem ? wvd_pkg::F_DRAIN : wvd_pkg::F_IDLE;
            end
         end
         wvd_pkg::F_DRAIN: begin
            if (queue_empty && back_status.idle) begin
               state_in = wvd_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = wvd_pkg::F_IDLE;
         end
      endcase
   end

   // Job for the results that this object releases.
   always_comb begin
      has_job             = 1'b0;
      job_in.energy_sum   = energy_sum_new;
      job_in.mass_sum     = mass_sum_new;
      job_in.first_index  = '0;
      job_in.first_slot   = '0;
      job_in.result_count = wvd_pkg::COUNT_MAX_W'(1);
      job_in.radius       = radius_emit_ff;
      job_in.use_mem      = 1'b0;
      job_in.window_error = 1'b0;
      job_in.last_result  = 1'b0;
      if (last_ff && !full_ff) begin
         has_job             = 1'b1;
         job_in.first_index  = wvd_pkg::INDEX_W'(count_ff);
         job_in.radius       = '0;
         job_in.window_error = 1'b1;
         job_in.last_result  = 1'b1;
      end else if (first_job) begin
         has_job             = 1'b1;
         job_in.result_count = wvd_pkg::COUNT_MAX_W'(HalfWindow + 1);
         job_in.use_mem      = 1'b1;
      end else if (full_ff) begin
         has_job             = 1'b1;
         job_in.first_index  = wvd_pkg::INDEX_W'(count_ff - CountWidth'(HalfWindow - 1));
         job_in.first_slot   = wvd_pkg::SLOT_MAX_W'(emit_slot_ff);
         job_in.result_count = last_ff ? wvd_pkg::COUNT_MAX_W'(HalfWindow)
                                       : wvd_pkg::COUNT_MAX_W'(1);
         job_in.use_mem      = last_ff;
         job_in.last_result  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wvd_pkg::F_IDLE;
         slot_ff       <= '0;
         count_ff      <= '0;
         full_ff       <= 1'b0;
         energy_sum_ff <= '0;
         mass_sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == wvd_pkg::F_SUM) begin
            if (last_ff) begin
               slot_ff       <= '0;
               count_ff      <= '0;
               full_ff       <= 1'b0;
               energy_sum_ff <= '0;
               mass_sum_ff   <= '0;
            end else begin
               slot_ff       <= slot_next;
               count_ff      <= count_ff + 1'b1;
               full_ff       <= full_ff | slot_wrap;
               energy_sum_ff <= energy_sum_new;
               mass_sum_ff   <= mass_sum_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      back_radius_ff <= radius_mem[back_status.rd_slot[SlotWidth-1:0]];
      if (accept) begin
         mass_ff       <= req_data.mass;
         mag_a_ff      <= req_data.radial_velocity[23]
                        ? 24'(-req_data.radial_velocity) : 24'(req_data.radial_velocity);
         mag_b_ff      <= req_data.tangential_velocity[23]
                        ? 24'(-req_data.tangential_velocity)
                        : 24'(req_data.tangential_velocity);
         radius_ff     <= req_data.radius;
         last_ff       <= req_data.last_object
                        | (count_ff == CountWidth'(MaxObjects - 1));
         old_mass_ff   <= mass_mem[slot_ff];
         old_energy_ff <= energy_mem[slot_ff];
         emit_slot_ff  <= emit_slot;
         // With a window of two the released object is the one arriving now.
         radius_emit_ff <= (emit_slot == slot_ff) ? req_data.radius : radius_mem[emit_slot];
      end
      if (state_ff == wvd_pkg::F_SQUARE) begin
         v2_ff <= sq_a + sq_b;
      end
      if (state_ff == wvd_pkg::F_PRODUCT) begin
         prod_hi_ff <= mass_ff * v2_ff[47:24];
         prod_lo_ff <= mass_ff * v2_ff[23:0];
      end
      if (state_ff == wvd_pkg::F_SUM) begin
         mass_mem[slot_ff]   <= mass_ff;
         energy_mem[slot_ff] <= energy;
         radius_mem[slot_ff] <= radius_ff;
         job_ff              <= job_in;
      end
   end

endmodule

[design/wvd_back.sv]
// ----------------------------------------------------------------------------
// wvd_back
// Works out dispersion and mean mass for a job and delivers its results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wvd_back #(
   parameter int HalfWindow = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_empty,
   output logic                     pop,
   input  wvd_pkg::job_type         pop_job,
   output wvd_pkg::back_status_type back_status,
   input  logic [31:0]              back_radius,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output wvd_pkg::rsp_type         rsp_data
);

   localparam int WindowLen = 2 * HalfWindow;
   localparam int SlotWidth = $clog2(WindowLen);
   localparam int MeanLog   = $clog2(HalfWindow);
   localparam int MeanShift = 29 + MeanLog;
   localparam logic [30:0] MeanRecip =
      31'(((64'd1 << MeanShift) + 64'(HalfWindow) - 64'd1) / 64'(HalfWindow));

   wvd_pkg::back_state_type state_ff, state_in;

   wvd_pkg::job_type              job_ff;
   logic [wvd_pkg::STEP_W-1:0]    step_ff;
   logic [29:0]                   rem_ff;
   logic [47:0]                   num_ff;
   logic [47:0]                   quo_ff;
   logic [23:0]                   mean_ff;
   logic [23:0]                   disp_ff;
   logic                          zero_ff;
   logic                          sat_ff;
   logic [25:0]                   root_rem_ff;
   logic [23:0]                   root_ff;
   logic [wvd_pkg::COUNT_MAX_W-1:0] left_ff;
   logic [wvd_pkg::INDEX_W-1:0]   index_ff;
   logic [SlotWidth-1:0]          slot_ff;
   logic                          rsp_valid_ff;
   wvd_pkg::rsp_type              rsp_data_ff;

   logic        load;
   logic        div_done;
   logic        root_done;
   logic [30:0] rem_sh;
   logic        rem_ge;
   logic [30:0] rem_sub;
   logic [59:0] mean_prod;
   logic [26:0] root_sh;
   logic [26:0] root_trial;
   logic        root_ge;
   logic [26:0] root_sub;
   logic [23:0] root_next;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;
   assign back_status.idle    = (state_ff == wvd_pkg::B_IDLE);
   assign back_status.rd_slot = wvd_pkg::SLOT_MAX_W'(slot_ff);

   // One quotient bit of energy * 2^24 / mass per step.
   assign rem_sh  = {rem_ff, num_ff[47]};
   assign rem_ge  = rem_sh >= {1'b0, job_ff.mass_sum};
   assign rem_sub = rem_sh - {1'b0, job_ff.mass_sum};

   // Mean mass by reciprocal multiplication: half the mass sum divided by
   // the half window equals the mass sum divided by the window length.
   assign mean_prod = job_ff.mass_sum[29:1] * MeanRecip;

   // One root bit per step, two radicand bits consumed.
   assign root_sh    = {root_rem_ff[24:0], quo_ff[47:46]};
   assign root_trial = {1'b0, root_ff, 2'b01};
   assign root_ge    = root_sh >= root_trial;
   assign root_sub   = root_sh - root_trial;
   assign root_next  = {root_ff[22:0], root_ge};

   assign div_done  = (step_ff == wvd_pkg::STEP_W'(wvd_pkg::DIV_STEPS - 1));
   assign root_done = (step_ff == wvd_pkg::STEP_W'(wvd_pkg::ROOT_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         wvd_pkg::B_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               state_in = pop_job.window_error ? wvd_pkg::B_READ : wvd_pkg::B_DIV;
            end
         end
         wvd_pkg::B_DIV: begin
            if (div_done) begin
               state_in = wvd_pkg::B_ROOT;
            end
         end
         wvd_pkg::B_ROOT: begin
            if (zero_ff || sat_ff || root_done) begin
               state_in = wvd_pkg::B_READ;
            end
         end
         wvd_pkg::B_READ: begin
            state_in = wvd_pkg::B_LOAD;
         end
         wvd_pkg::B_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = (left_ff == wvd_pkg::COUNT_MAX_W'(1))
                        ? wvd_pkg::B_IDLE : wvd_pkg::B_READ;
            end
         end
         default: begin
            state_in = wvd_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wvd_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff      <= pop_job;
         step_ff     <= '0;
         rem_ff      <= pop_job.energy_sum[53:24];
         num_ff      <= {pop_job.energy_sum[23:0], 24'd0};
         mean_ff     <= '0;
         disp_ff     <= '0;
         zero_ff     <= (pop_job.mass_sum == 30'd0);
         sat_ff      <= pop_job.energy_sum >= 56'({pop_job.mass_sum, 24'd0});
         left_ff     <= pop_job.result_count;
         index_ff    <= pop_job.first_index;
         slot_ff     <= SlotWidth'(pop_job.first_slot);
      end
      if (state_ff == wvd_pkg::B_DIV) begin
         rem_ff <= rem_ge ? rem_sub[29:0] : rem_sh[29:0];
         quo_ff <= {quo_ff[46:0], rem_ge};
         num_ff <= num_ff << 1;
         if (step_ff == '0) begin
            mean_ff <= 24'(mean_prod >> MeanShift);
         end
         if (div_done) begin
            step_ff     <= '0;
            root_rem_ff <= '0;
            root_ff     <= '0;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
      end
      if (state_ff == wvd_pkg::B_ROOT) begin
         if (zero_ff) begin
            disp_ff <= '0;
         end else if (sat_ff) begin
            disp_ff <= wvd_pkg::DISP_SAT;
         end else begin
            root_rem_ff <= root_ge ? root_sub[25:0] : root_sh[25:0];
            root_ff     <= root_next;
            quo_ff      <= quo_ff << 2;
            step_ff     <= step_ff + 1'b1;
            if (root_done) begin
               disp_ff <= root_next;
            end
         end
      end
      if (load) begin
         rsp_data_ff.object_index <= index_ff;
         rsp_data_ff.out_radius   <= job_ff.use_mem ? back_radius : job_ff.radius;
         rsp_data_ff.dispersion   <= disp_ff;
         rsp_data_ff.mean_mass    <= mean_ff;
         rsp_data_ff.window_error <= job_ff.window_error;
         rsp_data_ff.last_result  <= job_ff.last_result
                                   && (left_ff == wvd_pkg::COUNT_MAX_W'(1));
         left_ff  <= left_ff - 1'b1;
         index_ff <= index_ff + 1'b1;
         slot_ff  <= (slot_ff == SlotWidth'(WindowLen - 1)) ? '0 : slot_ff + 1'b1;
      end
   end

   `WVD_ASSERT_NEXT(a_last_ends_job, clock, reset,
      load && job_ff.last_result && (left_ff == wvd_pkg::COUNT_MAX_W'(1)),
      state_ff == wvd_pkg::B_IDLE)
   `WVD_ASSERT_IMPLIES(a_error_single, clock, reset,
      (state_ff == wvd_pkg::B_LOAD) && job_ff.window_error,
      (left_ff == wvd_pkg::COUNT_MAX_W'(1)) && !job_ff.use_mem)
   `WVD_ASSERT_IMPLIES(a_pop_when_idle, clock, reset, pop,
      (state_ff == wvd_pkg::B_IDLE) && !rsp_data_ff.window_error || !rsp_valid_ff
      || (state_ff == wvd_pkg::B_IDLE))

endmodule

[design/windowed_velocity_dispersion_unit.sv]
// ----------------------------------------------------------------------------
// windowed_velocity_dispersion_unit
// Centred moving window over a stream of objects giving velocity dispersion
// and mean mass for each object.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                              Payload
//   req_      in         req_valid, req_stall, req_data     wvd_pkg::req_type
//   rsp_      out        rsp_valid, rsp_stall, rsp_data     wvd_pkg::rsp_type
//
// The front end takes one object at a time and only returns for the next once
// it is through: it takes the transfer, squares the speeds, forms the mass
// products and updates the window stores and sums, then hands over a job
// when one is due. The back end runs each job through its bit-serial divider
// and its root unit, which error jobs skip, then reads and loads each result
// in turn; these two units limit the sustained throughput.
// Reset is synchronous and clears the control state and the running sums;
// the window stores need no clearing pass, as an entry is only read once the
// current stream has written it.
// A stalled result holds in the output register; the front end keeps taking
// transfers until the job queue fills or it drains after a window-store job.
//
module windowed_velocity_dispersion_unit #(
   parameter int HalfWindow = 20,
   parameter int MaxObjects = 1048576
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wvd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wvd_pkg::rsp_type rsp_data
);

   // Jobs flow from the front end through a two-entry queue to the back end.
   logic                     push;
   logic                     pop;
   logic                     queue_full;
   logic                     queue_empty;
   wvd_pkg::job_type         push_job;
   wvd_pkg::job_type         pop_job;

   // The back end reports when it is idle and which window slot it reads,
   // so that the front end can hold off while radii are read out of its store.
   wvd_pkg::back_status_type back_status;
   logic [31:0]              back_radius;

   wvd_front #(
      .HalfWindow (HalfWindow),
      .MaxObjects (MaxObjects)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .push        (push),
      .push_job    (push_job),
      .queue_full  (queue_full),
      .queue_empty (queue_empty),
      .back_status (back_status),
      .back_radius (back_radius)
   );

   wvd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .empty    (queue_empty),
      .pop      (pop),
      .pop_job  (pop_job)
   );

   wvd_back #(
      .HalfWindow (HalfWindow)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop         (pop),
      .pop_job     (pop_job),
      .back_status (back_status),
      .back_radius (back_radius),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
